@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL; used by sk256tc_ctrl.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sk256tc_pkg.sv @@
// Package for the Skein-256 truncated-carry hash unit: constants, tables,
// controller/datapath command and status types. No dependencies.
package sk256tc_pkg;

    // Round count and derived counter widths
    localparam int ROUND_COUNT = 72;
    localparam int SUB_LAST    = (ROUND_COUNT + 3) / 4;
    localparam int RND_W       = $clog2(ROUND_COUNT + 1);
    localparam int SUB_W       = $clog2(SUB_LAST + 2);

    localparam logic [RND_W-1:0] ROUND_END = RND_W'(ROUND_COUNT);
    localparam logic [SUB_W-1:0] SUB_END   = SUB_W'(SUB_LAST);

    // Carry chain configuration
    localparam int               CARRY_W   = 7;
    localparam logic [CARRY_W-1:0] CARRY_MAX = 7'd64;
    localparam logic [CARRY_W-1:0] CARRY_RST = 7'd64;

    // Key schedule parity and tweak type field (type 48 at bit 56)
    localparam logic [63:0] KS_PARITY  = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TWEAK_TYPE = 64'h3000_0000_0000_0000;
    localparam logic [63:0] BLOCK_BYTES = 64'd32;

    // Skein-256-256 initial chaining value
    localparam logic [63:0] IV_WORDS [4] = '{
        64'h1642_90A9_D4EE_EF1D, 64'h8E7E_AF44_B1B0_CD15,
        64'hA8BA_0822_F69D_09AE, 64'h0AF2_5C5E_364A_6468
    };

    // Threefish-256 rotation constants, indexed by round mod 8
    localparam logic [5:0] ROT_A [8] = '{
        6'd14, 6'd52, 6'd23, 6'd5, 6'd25, 6'd46, 6'd58, 6'd32
    };
    localparam logic [5:0] ROT_B [8] = '{
        6'd16, 6'd57, 6'd40, 6'd37, 6'd33, 6'd12, 6'd22, 6'd32
    };

    // Controller to datapath commands
    typedef struct packed {
        logic             load;      // take input word, build key and tweak
        logic             key_calc;  // compute subkey for sub_idx
        logic             inject;    // add subkey into state
        logic             fin;       // closing injection: update chaining value
        logic             step;      // one Threefish round
        logic [2:0]       rot_sel;
        logic [SUB_W-1:0] sub_idx;
        logic             load_out;  // move chaining value to output, restart
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // current block is the last of the message
        logic out_full;  // output register cannot take a new word
    } t_sts;

endpackage

@@ rtl/sk256tc_dp.sv @@
// Datapath of the Skein-256 truncated-carry hash unit: state words, key
// schedule, round and injection logic, output register. Uses sk256tc_pkg.
module sk256tc_dp import sk256tc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic [CARRY_W-1:0] i_cfg_wdata,
    input  logic [255:0]       i_tdata,
    input  logic               i_tlast,
    input  logic               i_out_ready,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic [255:0]       o_out_data
);

    // Addition with the carry chain cut after k ripple steps.
    // A carry survives only if its generating bit lies within k places below.
    function automatic logic [63:0] tadd(input logic [63:0] a, input logic [63:0] b,
                                         input logic [CARRY_W-1:0] k);
        logic [63:0]        p;
        logic [63:0]        cx;
        logic [63:0]        acc;
        logic [64:0]        s;
        logic [63:0]        win [7];
        logic [CARRY_W-1:0] off;
        p   = a ^ b;
        s   = {1'b0, a} + {1'b0, b};
        cx  = s[63:0] ^ p;
        // win[m][i]: propagate bits i-1 down to i-2^m all set
        win[0] = {p[62:0], 1'b0};
        for (int m = 1; m < 7; m++) begin
            win[m] = win[m-1] & (win[m-1] << (1 << (m - 1)));
        end
        // compose a window of length k from the power-of-two windows
        acc = '1;
        off = '0;
        for (int j = 0; j < 7; j++) begin
            if (k[j]) begin
                acc = acc & (win[j] << off);
                off = off + CARRY_W'(1 << j);
            end
        end
        return p ^ (cx & ~acc);
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] d;
        d = {x, x} << r;
        return d[127:64];
    endfunction

    // Control state
    logic [CARRY_W-1:0] r_carry;
    logic [63:0]        r_cv [4];
    logic               r_first;
    logic [63:0]        r_pos;
    logic               r_ovalid;

    // Payload registers
    logic [63:0] r_msg  [4];
    logic [63:0] r_rw   [4];
    logic [63:0] r_ek   [5];
    logic [63:0] r_tw   [3];
    logic [63:0] r_sk   [4];
    logic [63:0] r_hash [4];
    logic        r_last;

    logic [CARRY_W-1:0] k_eff;
    logic [63:0]        n_pos;
    logic [63:0]        tw1_new;
    logic [63:0]        ra0, ra2, rb1, rb3;
    logic [63:0]        inj    [4];
    logic [63:0]        sk_new [4];
    logic [63:0]        ek4_new;

    assign k_eff = (r_carry > CARRY_MAX) ? CARRY_MAX : r_carry;

    // Tweak and key parity for a new block
    assign n_pos   = r_pos + BLOCK_BYTES;
    assign tw1_new = TWEAK_TYPE | {i_tlast, r_first, 62'd0};
    assign ek4_new = KS_PARITY ^ r_cv[0] ^ r_cv[1] ^ r_cv[2] ^ r_cv[3];

    // One MIX round with word permutation
    assign ra0 = tadd(r_rw[0], r_rw[1], k_eff);
    assign ra2 = tadd(r_rw[2], r_rw[3], k_eff);
    assign rb1 = ra0 ^ rotl(r_rw[1], ROT_A[i_cmd.rot_sel]);
    assign rb3 = ra2 ^ rotl(r_rw[3], ROT_B[i_cmd.rot_sel]);

    // Subkey from the rotated key and tweak registers
    assign sk_new[0] = r_ek[0];
    assign sk_new[1] = tadd(r_ek[1], r_tw[0], k_eff);
    assign sk_new[2] = tadd(r_ek[2], r_tw[1], k_eff);
    assign sk_new[3] = tadd(r_ek[3], 64'(i_cmd.sub_idx), k_eff);

    // Subkey injection
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            inj[i] = tadd(r_rw[i], r_sk[i], k_eff);
        end
    end

    // Configuration, chaining value, position, first flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry  <= CARRY_RST;
            r_first  <= 1'b1;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_cv[i] <= IV_WORDS[i];
            end
        end else begin
            if (i_cfg_wen) begin
                r_carry <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_pos <= n_pos;
            end
            if (i_cmd.fin) begin
                r_first <= 1'b0;
                for (int i = 0; i < 4; i++) begin
                    r_cv[i] <= inj[i] ^ r_msg[i];
                end
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
                r_first  <= 1'b1;
                r_pos    <= '0;
                for (int i = 0; i < 4; i++) begin
                    r_cv[i] <= IV_WORDS[i];
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working words, key schedule, output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last  <= i_tlast;
            r_tw[0] <= n_pos;
            r_tw[1] <= tw1_new;
            r_tw[2] <= n_pos ^ tw1_new;
            r_ek[4] <= ek4_new;
            for (int i = 0; i < 4; i++) begin
                r_msg[i] <= i_tdata[64*i +: 64];
                r_rw[i]  <= i_tdata[64*i +: 64];
                r_ek[i]  <= r_cv[i];
            end
        end
        if (i_cmd.key_calc) begin
            for (int i = 0; i < 4; i++) begin
                r_sk[i] <= sk_new[i];
            end
        end
        // injection also rotates key and tweak for the next subkey
        if (i_cmd.inject) begin
            for (int i = 0; i < 4; i++) begin
                r_rw[i] <= inj[i];
                r_ek[i] <= r_ek[i+1];
            end
            r_ek[4] <= r_ek[0];
            r_tw[0] <= r_tw[1];
            r_tw[1] <= r_tw[2];
            r_tw[2] <= r_tw[0];
        end
        if (i_cmd.step) begin
            r_rw[0] <= ra0;
            r_rw[1] <= rb3;
            r_rw[2] <= ra2;
            r_rw[3] <= rb1;
        end
        if (i_cmd.load_out) begin
            for (int i = 0; i < 4; i++) begin
                r_hash[i] <= r_cv[i];
            end
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_full = r_ovalid & ~i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_data     = {r_hash[3], r_hash[2], r_hash[1], r_hash[0]};

endmodule

@@ rtl/sk256tc_ctrl.sv @@
// Controller of the Skein-256 truncated-carry hash unit: sequences key setup,
// rounds, injections and output hand-over. Uses sk256tc_pkg, assert_macros.svh.
`include "assert_macros.svh"

module sk256tc_ctrl import sk256tc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_KEY   = 5'b00010,
        S_INJ   = 5'b00100,
        S_ROUND = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [SUB_W-1:0] r_sub, n_sub;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_rnd         = r_rnd;
        n_sub         = r_sub;
        o_cmd         = '0;
        o_cmd.rot_sel = r_rnd[2:0];
        o_cmd.sub_idx = r_sub;
        o_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_rnd      = '0;
                    n_sub      = '0;
                    n_state    = S_KEY;
                end
            end
            S_KEY: begin
                o_cmd.key_calc = 1'b1;
                n_state        = S_INJ;
            end
            S_INJ: begin
                o_cmd.inject = 1'b1;
                n_sub        = r_sub + 1'b1;
                if (r_rnd == ROUND_END) begin
                    o_cmd.fin = 1'b1;
                    n_state   = i_sts.last ? S_OUT : S_IDLE;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                // next subkey is prepared while the rounds run
                o_cmd.step     = 1'b1;
                o_cmd.key_calc = 1'b1;
                n_rnd          = r_rnd + 1'b1;
                if (n_rnd == ROUND_END || n_rnd[1:0] == 2'b00) begin
                    n_state = S_INJ;
                end
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_sub   <= n_sub;
        end
    end

    // Checks
    `AST_IMP(a_rnd_range, i_clk, i_rst_n, 1'b1, r_rnd <= ROUND_END, "round count overran")
    `AST_IMP(a_inj_group, i_clk, i_rst_n, r_state == S_INJ, r_rnd[1:0] == 2'b00 || r_rnd == ROUND_END, "injection off a group boundary")
    `AST_IMP(a_fin_sub, i_clk, i_rst_n, o_cmd.fin, r_sub == SUB_END, "closing injection uses wrong subkey")
    `AST_NXT(a_out_free, i_clk, i_rst_n, o_cmd.load_out, !$past(i_sts.out_full), "output overwritten while held")

endmodule

@@ rtl/skein256_hash_truncated_carry_unit.sv @@
// Skein-256 truncated-carry hash unit: one 256-bit message word per block.
// A new block is accepted only in the idle state, once the previous block is through; after
// key setup, one round or injection per cycle. A last block adds an output hand-over state,
// which waits while the output word is held. Reset (synchronous, active low):
// carry_bits = 64, chaining value = IV, position = 0, first flag set, output empty.
module skein256_hash_truncated_carry_unit import sk256tc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic [CARRY_W-1:0] i_cfg_wdata,      // carry_bits
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [255:0]       s_axis_tdata,     // message_word0..message_word3
    input  logic               s_axis_tlast,     // last_block
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [255:0]       m_axis_tdata      // hash_word0..hash_word3
);

    t_cmd cmd;
    t_sts sts;

    sk256tc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sk256tc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tdata     (s_axis_tdata),
        .i_tlast     (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
